@@ rtl/cfp_pkg.sv @@
package cfp_pkg;

    // Number of 32-bit words carried in a frame payload.
    localparam int WORD_FIELDS = 6;
    // Number of 32-bit word fields on the result port.
    localparam int OUT_WORDS   = 6;
    localparam int WIDX_W      = (WORD_FIELDS > 1) ? $clog2(WORD_FIELDS) : 1;

    // Request queue between the header matcher and the frame parser.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register map.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_WORD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TAIL_BYTE   = 2'd1;

    localparam logic [31:0] HEADER_WORD_RESET = 32'hFFFE_FDF2;
    localparam logic [7:0]  TAIL_BYTE_RESET   = 8'h02;

    // One classified byte: restart is set when a header match completed on it.
    typedef struct packed {
        logic       restart;
        logic [7:0] data;
    } cfp_entry_t;

    typedef enum logic [2:0] {
        STG_WAIT,
        STG_KEY,
        STG_WORD,
        STG_RECEIPT,
        STG_TAIL
    } cfp_stage_t;

    typedef struct packed {
        logic [7:0]                 key_code;
        logic [OUT_WORDS-1:0][31:0] words;
        logic [7:0]                 receipt_code;
    } cfp_result_t;

endpackage

@@ rtl/cfp_front.sv @@
module cfp_front
    import cfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] header_word,
    input  logic        in_fire,
    input  logic [7:0]  rx_byte,
    output cfp_entry_t  push_entry
);

    logic [7:0] hdr_buf_reg [4];
    logic [7:0] hdr_buf_next [4];
    logic [2:0] cap_count_reg;
    logic [2:0] cap_count_next;
    logic       cap_active_reg;
    logic       cap_active_next;
    logic       match;
    logic       restart;

    always_comb
    begin
        match = 1'b1;
        for (int k = 0; k < 4; k++)
        begin
            if (hdr_buf_reg[k] != header_word[31 - 8*k -: 8])
            begin
                match = 1'b0;
            end
        end
    end

    // The capture window is checked one byte after it fills, and a fresh
    // start byte always restarts the window.
    always_comb
    begin
        cap_count_next  = cap_count_reg;
        cap_active_next = cap_active_reg;
        hdr_buf_next    = hdr_buf_reg;
        restart         = 1'b0;
        if (cap_count_reg == 3'd4)
        begin
            if (match)
            begin
                restart         = 1'b1;
                cap_active_next = 1'b0;
            end
            cap_count_next = 3'd0;
        end
        if (rx_byte == header_word[31:24])
        begin
            cap_count_next  = 3'd0;
            cap_active_next = 1'b1;
        end
        if (cap_active_next)
        begin
            hdr_buf_next[cap_count_next[1:0]] = rx_byte;
            cap_count_next = cap_count_next + 3'd1;
        end
    end

    assign push_entry.restart = restart;
    assign push_entry.data    = rx_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_count_reg  <= '0;
            cap_active_reg <= 1'b0;
            for (int k = 0; k < 4; k++)
            begin
                hdr_buf_reg[k] <= '0;
            end
        end
        else if (in_fire)
        begin
            cap_count_reg  <= cap_count_next;
            cap_active_reg <= cap_active_next;
            hdr_buf_reg    <= hdr_buf_next;
        end
    end

endmodule

@@ rtl/cfp_queue.sv @@
module cfp_queue
    import cfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  cfp_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output logic       not_empty,
    output cfp_entry_t head
);

    cfp_entry_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

@@ rtl/cfp_back.sv @@
module cfp_back
    import cfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  tail_byte,
    input  logic        entry_valid,
    input  cfp_entry_t  entry,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output cfp_result_t result
);

    cfp_stage_t        stage_reg;
    cfp_stage_t        stage_next;
    cfp_stage_t        eff_stage;
    logic [WIDX_W-1:0] word_idx_reg;
    logic [WIDX_W-1:0] word_idx_next;
    logic [1:0]        lane_reg;
    logic [1:0]        lane_next;
    logic [7:0]        key_reg;
    logic [7:0]        receipt_reg;
    logic [31:0]       word_regs_reg [WORD_FIELDS];
    logic              out_valid_reg;
    cfp_result_t       result_reg;
    cfp_result_t       snap;
    logic              key_we;
    logic              word_we;
    logic              receipt_we;
    logic              emit;

    assign pop       = entry_valid && (!out_valid_reg || out_ready);
    assign eff_stage = entry.restart ? STG_KEY : stage_reg;

    always_comb
    begin
        stage_next    = stage_reg;
        word_idx_next = word_idx_reg;
        lane_next     = lane_reg;
        if (pop)
        begin
            unique case (eff_stage)
                STG_WAIT:
                begin
                    stage_next = STG_WAIT;
                end
                STG_KEY:
                begin
                    stage_next    = STG_WORD;
                    word_idx_next = '0;
                end
                STG_WORD:
                begin
                    lane_next = lane_reg + 2'd1;
                    if (lane_reg == 2'd3)
                    begin
                        if (word_idx_reg == WIDX_W'(WORD_FIELDS - 1))
                        begin
                            stage_next = STG_RECEIPT;
                        end
                        else
                        begin
                            word_idx_next = word_idx_reg + WIDX_W'(1);
                        end
                    end
                end
                STG_RECEIPT:
                begin
                    stage_next = STG_TAIL;
                end
                STG_TAIL:
                begin
                    if (entry.data == tail_byte)
                    begin
                        stage_next = STG_WAIT;
                    end
                end
                default:
                begin
                    stage_next = STG_WAIT;
                end
            endcase
        end
    end

    always_comb
    begin
        key_we     = pop && (eff_stage == STG_KEY);
        word_we    = pop && (eff_stage == STG_WORD);
        receipt_we = pop && (eff_stage == STG_RECEIPT);
        emit       = pop && (eff_stage == STG_TAIL) && (entry.data == tail_byte);
    end

    assign snap.key_code     = key_reg;
    assign snap.receipt_code = receipt_reg;
    for (genvar k = 0; k < OUT_WORDS; k++)
    begin : g_snap
        if (k < WORD_FIELDS)
        begin : g_word
            assign snap.words[k] = word_regs_reg[k];
        end
        else
        begin : g_zero
            assign snap.words[k] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg     <= STG_WAIT;
            word_idx_reg  <= '0;
            lane_reg      <= '0;
            key_reg       <= '0;
            receipt_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < WORD_FIELDS; k++)
            begin
                word_regs_reg[k] <= '0;
            end
        end
        else
        begin
            stage_reg    <= stage_next;
            word_idx_reg <= word_idx_next;
            lane_reg     <= lane_next;
            if (key_we)
            begin
                key_reg <= entry.data;
            end
            if (receipt_we)
            begin
                receipt_reg <= entry.data;
            end
            if (word_we)
            begin
                word_regs_reg[word_idx_reg][8*lane_reg +: 8] <= entry.data;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            result_reg <= snap;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

@@ rtl/command_frame_parser.sv @@
// A request carrying an accepted tail byte is written into the queue when it is
// accepted; the parser then pops it and loads the result register, which drives
// the result port.
// Throughput: one byte per cycle while the queue has room; a four-entry queue lets
// the header matcher keep accepting while a finished frame waits on the result port.
// Reset (rst_n, asynchronous, active low) empties the queue, clears the matcher and
// parser state and frame registers, and restores header_word and tail_byte defaults.
module command_frame_parser
    import cfp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration write port.
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data,
    // Received byte requests.
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             rx_byte,
    // Parsed frame requests.
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             key_code,
    output logic [31:0]            coord_x,
    output logic [31:0]            coord_y,
    output logic [31:0]            coord_angle,
    output logic [31:0]            wheel_speed,
    output logic [31:0]            release_position,
    output logic [31:0]            pitch_position,
    output logic [7:0]             receipt_code
);

    logic [31:0] header_word_reg;
    logic [7:0]  tail_byte_reg;
    logic        q_full;
    logic        q_not_empty;
    logic        q_pop;
    logic        in_fire;
    cfp_entry_t  push_entry;
    cfp_entry_t  head_entry;
    cfp_result_t result;

    // Configuration registers. The user must make writes only while the block is
    // idle (the block does not enforce it), so the matcher and parser may use them directly.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_word_reg <= HEADER_WORD_RESET;
            tail_byte_reg   <= TAIL_BYTE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HEADER_WORD: header_word_reg <= cfg_data;
                REG_TAIL_BYTE:   tail_byte_reg   <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    // The front end takes a byte whenever the queue has room; it never waits
    // on the result port directly.
    assign in_ready = !q_full;
    assign in_fire  = in_valid && in_ready;

    // Header matcher: tags each byte with whether a header match completes on
    // it, which restarts the parser at the key byte.
    cfp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .header_word (header_word_reg),
        .in_fire     (in_fire),
        .rx_byte     (rx_byte),
        .push_entry  (push_entry)
    );

    cfp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_fire),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (head_entry)
    );

    // Frame parser: walks key, payload words, receipt and tail, and loads the
    // result register when a tail byte matches. It only stalls while a
    // finished frame is still waiting to be taken.
    cfp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .tail_byte   (tail_byte_reg),
        .entry_valid (q_not_empty),
        .entry       (head_entry),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result      (result)
    );

    assign key_code         = result.key_code;
    assign coord_x          = result.words[0];
    assign coord_y          = result.words[1];
    assign coord_angle      = result.words[2];
    assign wheel_speed      = result.words[3];
    assign release_position = result.words[4];
    assign pitch_position   = result.words[5];
    assign receipt_code     = result.receipt_code;

endmodule

@@ rtl/cfp_checker.sv @@
module cfp_checker
    import cfp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  key_code,
    input logic [31:0] coord_x,
    input logic [31:0] pitch_position,
    input logic [7:0]  receipt_code
);

    // A frame that is not taken stays on the port.
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid;
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("result dropped before it was taken");

    property p_out_stable;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(key_code) && $stable(coord_x)
            && $stable(pitch_position) && $stable(receipt_code);
    endproperty
    a_out_stable: assert property (p_out_stable)
        else $error("result payload changed while stalled");

    // Once reset has been seen at an edge, no result is shown at the next one.
    property p_reset_quiet;
        @(posedge clk)
        !rst_n |=> !out_valid;
    endproperty
    a_reset_quiet: assert property (p_reset_quiet)
        else $error("result valid during reset");

    // The queue can only fill while a finished frame is stalled.
    property p_full_needs_stall;
        @(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid;
    endproperty
    a_full_needs_stall: assert property (p_full_needs_stall)
        else $error("input stalled with no result waiting");

    // Frames are far apart, so a taken result is never followed at once by another.
    property p_frame_spacing;
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid;
    endproperty
    a_frame_spacing: assert property (p_frame_spacing)
        else $error("two results without a full frame between them");

endmodule

bind command_frame_parser cfp_checker u_cfp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .key_code       (key_code),
    .coord_x        (coord_x),
    .pitch_position (pitch_position),
    .receipt_code   (receipt_code)
);

@@ tb/sv/command_frame_parser_tb.sv @@
module command_frame_parser_tb
    import cfp_pkg::*;
();

    // Timing and stimulus shape.
    localparam int RESET_CYCLES  = 7;
    localparam int IDLE_PCT      = 28;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 2000;
    localparam int NUM_PHASES    = 6;
    localparam int PHASE_ITEMS   = 225;
    localparam int DIR_ROWS      = 36;

    // Register indexes that the block decodes to nothing.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

    // Parser stage coding of the predictor: wait, key, one stage per word,
    // receipt, tail.
    localparam logic [3:0] ST_WAIT    = 4'd0;
    localparam logic [3:0] ST_KEY     = 4'd1;
    localparam logic [3:0] ST_WORD0   = 4'd2;
    localparam logic [3:0] ST_RECEIPT = 4'(WORD_FIELDS + 2);
    localparam logic [3:0] ST_TAIL    = 4'(WORD_FIELDS + 3);

    // Every input of the block holds a known value from time zero.
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [31:0]            cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    logic [7:0]             rx_byte   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [7:0]             key_code;
    logic [31:0]            coord_x;
    logic [31:0]            coord_y;
    logic [31:0]            coord_angle;
    logic [31:0]            wheel_speed;
    logic [31:0]            release_position;
    logic [31:0]            pitch_position;
    logic [7:0]             receipt_code;

    command_frame_parser DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .rx_byte          (rx_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .key_code         (key_code),
        .coord_x          (coord_x),
        .coord_y          (coord_y),
        .coord_angle      (coord_angle),
        .wheel_speed      (wheel_speed),
        .release_position (release_position),
        .pitch_position   (pitch_position),
        .receipt_code     (receipt_code)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor copy of the configuration registers, at their reset values.
    logic [31:0] cfg_header = HEADER_WORD_RESET;
    logic [7:0]  cfg_tail   = TAIL_BYTE_RESET;

    // Predictor copy of the matcher and parser state, all cleared by reset.
    logic [7:0]  hdr_buf [4] = '{default: '0};
    logic [2:0]  cap_count = '0;
    logic        cap_on    = 1'b0;
    logic [3:0]  stage_q   = ST_WAIT;
    logic [1:0]  lane      = '0;
    logic [7:0]  key_q     = '0;
    logic [31:0] word_q [WORD_FIELDS] = '{default: '0};
    logic [7:0]  receipt_q = '0;

    // Frames predicted from accepted byte requests, oldest first.
    cfp_result_t frames_due [$];
    cfp_result_t head_frame;

    // Bytes of the random chunk that is about to be sent.
    logic [7:0]  chunk [$];

    int          err_count = 0;
    int          quiet     = 0;
    bit          steady    = 1'b0;

    // The directed table. The first four bytes begin a header that goes wrong
    // on its last byte, so the capture must run on and still find the real
    // header right behind it. The frame that follows carries the extremes of
    // the key, receipt and word fields, and its tail is preceded by one wrong
    // tail byte, which must leave the parser waiting at the tail.
    logic [7:0]  dir_bytes [DIR_ROWS] = '{
        8'hFF, 8'hFE, 8'hFD, 8'h00,
        8'hFF, 8'hFE, 8'hFD, 8'hF2,
        8'h00,
        8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'h00, 8'h00, 8'h00, 8'h00,
        8'h78, 8'h56, 8'h34, 8'h12,
        8'h01, 8'h00, 8'h00, 8'h80,
        8'hFE, 8'hFD, 8'hF2, 8'h00,
        8'hAA, 8'h55, 8'hAA, 8'h55,
        8'hFF,
        8'h00,
        8'h02
    };
    cfp_result_t dir_frame;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s: got %h, expected %h", what, got, want);
        err_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // One byte through the predicted matcher and parser. Returns 1 when the
    // byte closes a frame, with the frame in 'frame'.
    function automatic bit parse_byte(input logic [7:0] b, output cfp_result_t frame);
        bit hit;
        int w;
        hit   = 1'b0;
        frame = '0;

        // The header matcher looks at the capture on the byte after four
        // captured bytes. A mismatch only restarts the count; capture runs on.
        if (cap_count == 3'd4) begin
            if (cfg_header == {hdr_buf[0], hdr_buf[1], hdr_buf[2], hdr_buf[3]}) begin
                stage_q = ST_KEY;
                cap_on  = 1'b0;
            end
            cap_count = '0;
        end
        if (b == cfg_header[31:24]) begin
            cap_count = '0;
            cap_on    = 1'b1;
        end
        if (cap_on) begin
            hdr_buf[cap_count[1:0]] = b;
            cap_count = cap_count + 3'd1;
        end

        // The frame parser. A header found mid-frame sends it back to the key
        // byte, but the byte lane is kept, so a half-filled word goes on at
        // the lane where it stood.
        if (stage_q == ST_KEY) begin
            key_q   = b;
            stage_q = stage_q + 4'd1;
        end else if (stage_q >= ST_WORD0 && stage_q < ST_RECEIPT) begin
            w = int'(stage_q - ST_WORD0);
            word_q[w][8*lane +: 8] = b;
            lane = lane + 2'd1;
            if (lane == 2'd0)
                stage_q = stage_q + 4'd1;
        end else if (stage_q == ST_RECEIPT) begin
            receipt_q = b;
            stage_q   = stage_q + 4'd1;
        end else if (stage_q == ST_TAIL && b == cfg_tail) begin
            // Word registers are reported as they stand, stale bytes and all.
            stage_q = ST_WAIT;
            frame.key_code = key_q;
            for (int k = 0; k < OUT_WORDS; k++)
                if (k < WORD_FIELDS)
                    frame.words[k] = word_q[k];
            frame.receipt_code = receipt_q;
            hit = 1'b1;
        end
        return hit;
    endfunction

    // Random byte with the two extremes weighted up.
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Fills 'chunk' with one random piece of the stream. Most pieces are
    // complete frames under the current header and tail, so the parser gets
    // all the way through; the rest are frames cut short (the next header then
    // restarts the parser mid-frame), line noise, and headers that go wrong.
    function automatic void build_chunk();
        int         kind;
        int         n;
        logic [7:0] b;
        chunk.delete();
        kind = $urandom_range(0, 99);
        if (kind < 88 && kind >= 76) begin
            n = $urandom_range(1, 8);
            repeat (n) chunk.push_back(rand_byte());
        end else if (kind >= 88) begin
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++)
                chunk.push_back(cfg_header[31 - 8*k -: 8]);
            chunk.push_back(rand_byte());
        end else begin
            for (int k = 0; k < 4; k++)
                chunk.push_back(cfg_header[31 - 8*k -: 8]);
            chunk.push_back(rand_byte());
            if (kind < 62) begin
                repeat (4 * WORD_FIELDS + 1) chunk.push_back(rand_byte());
                if ($urandom_range(0, 3) == 0) begin
                    n = $urandom_range(1, 3);
                    repeat (n) begin
                        do
                            b = rand_byte();
                        while (b == cfg_tail);
                        chunk.push_back(b);
                    end
                end
                chunk.push_back(cfg_tail);
            end else begin
                n = $urandom_range(0, 4 * WORD_FIELDS + 1);
                repeat (n) chunk.push_back(rand_byte());
            end
        end
    endfunction

    // Offers one byte request, after a random gap, and holds it until the
    // block takes it. The prediction is made on acceptance. A typed row
    // supplies its own expected frame in place of the predicted one.
    task automatic send_byte(input logic [7:0] b, input bit typed, input cfp_result_t want);
        cfp_result_t frame;
        bit          hit;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        hit = parse_byte(b, frame);
        if (typed)
            frames_due.push_back(want);
        else if (hit)
            frames_due.push_back(frame);
    endtask

    // Stops sending and waits until every predicted frame has come out, then
    // lets the pipeline settle, since a byte that closes no frame may still
    // be inside the block.
    task automatic drain_frames();
        in_valid <= 1'b0;
        @(posedge clk);
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; only called while the block is idle.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_HEADER_WORD)
            cfg_header = data;
        else if (idx == REG_TAIL_BYTE)
            cfg_tail = data[7:0];
        @(posedge clk);
    endtask

    // Frame receiver: checks each accepted frame request against the oldest
    // prediction, and stalls at random outside the steady phase.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) begin
            if (frames_due.size() == 0) begin
                report_mismatch("frame with none expected, key_code", 32'(key_code), '0);
            end else begin
                head_frame = frames_due.pop_front();
                check_field("key_code", 32'(key_code), 32'(head_frame.key_code));
                check_field("coord_x", coord_x, head_frame.words[0]);
                check_field("coord_y", coord_y, head_frame.words[1]);
                check_field("coord_angle", coord_angle, head_frame.words[2]);
                check_field("wheel_speed", wheel_speed, head_frame.words[3]);
                check_field("release_position", release_position, head_frame.words[4]);
                check_field("pitch_position", pitch_position, head_frame.words[5]);
                check_field("receipt_code", 32'(receipt_code),
                            32'(head_frame.receipt_code));
            end
        end
        out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Watchdog: the run is hung if no request moves on either side for too
    // long. Random gaps and stalls are short next to this limit.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : stimulus
        int          phase;
        int          sent;
        logic [31:0] hdr;
        logic [31:0] tail_data;

        // Expected frame of the directed table, read straight off its bytes:
        // words are little-endian, first byte in bits 7..0.
        dir_frame              = '0;
        dir_frame.key_code     = 8'h00;
        dir_frame.words[0]     = 32'hFFFF_FFFF;
        dir_frame.words[1]     = 32'h0000_0000;
        dir_frame.words[2]     = 32'h1234_5678;
        dir_frame.words[3]     = 32'h8000_0001;
        dir_frame.words[4]     = 32'h00F2_FDFE;
        dir_frame.words[5]     = 32'h55AA_55AA;
        dir_frame.receipt_code = 8'hFF;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Each phase runs under one register setting. Phase zero keeps the
        // reset values; later phases move both registers to their extremes,
        // to random values, and back. The spare indexes are written too and
        // must change nothing. Phase three runs with no gaps on either side.
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase != 0) begin
                case (phase)
                    1: begin
                        hdr       = 32'hFFFF_FFFF;
                        tail_data = 32'hFF;
                    end
                    2: begin
                        hdr       = 32'h0000_0000;
                        tail_data = 32'h00;
                    end
                    5: begin
                        hdr       = HEADER_WORD_RESET;
                        tail_data = {24'h0, TAIL_BYTE_RESET};
                    end
                    default: begin
                        hdr       = $urandom();
                        tail_data = $urandom_range(0, 255);
                    end
                endcase
                // Bits above the tail byte are junk the register must drop.
                tail_data[31:8] = 24'($urandom());
                write_reg(REG_SPARE_A, $urandom());
                write_reg(REG_HEADER_WORD, hdr);
                write_reg(REG_TAIL_BYTE, tail_data);
                write_reg(REG_SPARE_B, $urandom());
            end

            steady = (phase == 3);
            sent   = 0;

            if (phase == 0) begin
                for (int i = 0; i < DIR_ROWS; i++) begin
                    send_byte(dir_bytes[i], i == DIR_ROWS - 1, dir_frame);
                    sent++;
                end
            end

            while (sent < PHASE_ITEMS) begin
                build_chunk();
                foreach (chunk[i]) begin
                    send_byte(chunk[i], 1'b0, '0);
                    sent++;
                end
                // Now and then the sender holds off until the block has
                // handed over every frame it owes.
                if ($urandom_range(0, 19) == 0)
                    drain_frames();
            end

            drain_frames();
        end

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
